@@ rtl/csrd_pkg.sv @@
// Shared types and constants for the call site redirector.
`timescale 1ns / 1ps

package csrd_pkg;

    // Input item opcodes.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Opcode bytes that are recognized or written.
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_15 = 8'h15;
    localparam logic [7:0] BYTE_E8 = 8'hE8;
    localparam logic [7:0] BYTE_90 = 8'h90;

    // Window length and length of an E8 rel32 call.
    localparam int WIN_LEN = 6;
    localparam logic [31:0] CALL_LEN = 32'd5;
    localparam logic [2:0] WIN_FULL = 3'd6;

    // Patch kinds reported on the first byte of a call.
    localparam logic [1:0] PATCH_NONE     = 2'd0;
    localparam logic [1:0] PATCH_INDIRECT = 2'd1;
    localparam logic [1:0] PATCH_DIRECT   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PREF_BASE    = 2'd0;
    localparam logic [1:0] REG_IMPORT_START = 2'd1;
    localparam logic [1:0] REG_IMPORT_SIZE  = 2'd2;
    localparam logic [1:0] REG_ACTIVE_STUBS = 2'd3;

    localparam logic [31:0] PREF_BASE_RESET = 32'h0040_0000;

    // Request queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPW    = 1;

    typedef struct packed {
        logic [31:0] pref_base;
        logic [31:0] import_dir_start;
        logic [31:0] import_dir_size;
        logic [4:0]  active_stubs;
    } cfg_t;

    typedef struct packed {
        logic        is_load;
        logic [7:0]  code_byte;
        logic [31:0] byte_address;
        logic        section_end;
        logic [3:0]  slot_index;
        logic [31:0] slot_table_addr;
        logic [31:0] slot_orig_target;
        logic [31:0] slot_stub_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] slot_addr;
        logic [31:0] orig_target;
        logic [31:0] dest_addr;
    } stub_t;

endpackage

@@ rtl/call_site_redirector_unit.sv @@
// Call site redirector: rewrites x86 call sites in a streamed code section to aim at stubs.
// Flow: each scan byte moves from the queue into the window; with a full window the oldest
// byte is checked as a call candidate against at most the active stub count of slots, capped
// at STUB_DEPTH, and then emitted; at a section end the remaining bytes are flushed without a
// search. A load only writes its stub entry; the queue is popped only while the back end is idle.
// Reset: rst_n empties window and queue, drops any output, resets configuration; stubs undefined.
`timescale 1ns / 1ps

module call_site_redirector_unit #(
    parameter int STUB_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  code_byte,
    input  logic [31:0] byte_address,
    input  logic        section_end,
    input  logic [3:0]  slot_index,
    input  logic [31:0] slot_table_addr,
    input  logic [31:0] slot_orig_target,
    input  logic [31:0] slot_stub_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [31:0] out_address,
    output logic [1:0]  patch_kind,
    output logic        run_last
);
    import csrd_pkg::*;

    cfg_t cfg_reg;
    req_t q_head;
    logic q_valid;
    logic q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pref_base        <= PREF_BASE_RESET;
            cfg_reg.import_dir_start <= '0;
            cfg_reg.import_dir_size  <= '0;
            cfg_reg.active_stubs     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PREF_BASE:    cfg_reg.pref_base        <= cfg_data;
                REG_IMPORT_START: cfg_reg.import_dir_start <= cfg_data;
                REG_IMPORT_SIZE:  cfg_reg.import_dir_size  <= cfg_data;
                REG_ACTIVE_STUBS: cfg_reg.active_stubs     <= cfg_data[4:0];
                default:          cfg_reg.active_stubs     <= cfg_reg.active_stubs;
            endcase
        end
    end

    csrd_front #(
        .STUB_DEPTH(STUB_DEPTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .code_byte        (code_byte),
        .byte_address     (byte_address),
        .section_end      (section_end),
        .slot_index       (slot_index),
        .slot_table_addr  (slot_table_addr),
        .slot_orig_target (slot_orig_target),
        .slot_stub_addr   (slot_stub_addr),
        .q_head           (q_head),
        .q_valid          (q_valid),
        .q_pop            (q_pop)
    );

    csrd_back #(
        .STUB_DEPTH(STUB_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_head      (q_head),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_address (out_address),
        .patch_kind  (patch_kind),
        .run_last    (run_last)
    );

endmodule

@@ rtl/csrd_front.sv @@
// Front end: accepts requests, drops loads to slots beyond the table, queues the rest.
`timescale 1ns / 1ps

module csrd_front #(
    parameter int STUB_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [7:0]            code_byte,
    input  logic [31:0]           byte_address,
    input  logic                  section_end,
    input  logic [3:0]            slot_index,
    input  logic [31:0]           slot_table_addr,
    input  logic [31:0]           slot_orig_target,
    input  logic [31:0]           slot_stub_addr,
    output csrd_pkg::req_t        q_head,
    output logic                  q_valid,
    input  logic                  q_pop
);
    import csrd_pkg::*;

    req_t             q_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QPW:0]     cnt_reg;
    logic [QPW:0]     cnt_next;
    logic             accept;
    logic             push;
    logic             pop;
    logic             slot_ok;
    req_t             req;

    assign in_stall = (cnt_reg == (QPW + 1)'(QDEPTH));
    assign accept   = in_valid && !in_stall;
    assign slot_ok  = (32'(slot_index) < 32'(STUB_DEPTH));
    // A load to a slot the table does not have has no effect, so it never enters the queue.
    assign push     = accept && ((opcode == OP_SCAN) || slot_ok);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        req.is_load          = (opcode == OP_LOAD);
        req.code_byte        = code_byte;
        req.byte_address     = byte_address;
        req.section_end      = section_end;
        req.slot_index       = slot_index;
        req.slot_table_addr  = slot_table_addr;
        req.slot_orig_target = slot_orig_target;
        req.slot_stub_addr   = slot_stub_addr;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

@@ rtl/csrd_back.sv @@
// Back end: byte window, stub table search, call rewriting and the output register.
`timescale 1ns / 1ps

module csrd_back #(
    parameter int STUB_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  csrd_pkg::cfg_t   cfg,
    input  csrd_pkg::req_t   q_head,
    input  logic             q_valid,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic [31:0]      out_address,
    output logic [1:0]       patch_kind,
    output logic             run_last
);
    import csrd_pkg::*;

    localparam int SW = (STUB_DEPTH > 1) ? $clog2(STUB_DEPTH) : 1;
    localparam int CW = $clog2(STUB_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_CAND   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [2:0]    fill_reg;
    logic [2:0]    fill_next;
    logic [31:0]   oldest_reg;
    logic [31:0]   oldest_next;
    logic          end_reg;
    logic          end_next;
    logic [1:0]    mode_reg;
    logic [1:0]    mode_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic [31:0]   key_reg;
    logic [31:0]   key_next;
    logic [31:0]   base5_reg;
    logic [31:0]   base5_next;
    logic [CW-1:0] srch_reg;
    logic [CW-1:0] srch_next;
    logic [7:0]    win_reg [WIN_LEN];
    logic [7:0]    win_next [WIN_LEN];

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic [31:0]   out_addr_reg;
    logic [31:0]   out_addr_next;
    logic [1:0]    out_kind_reg;
    logic [1:0]    out_kind_next;
    logic          out_last_reg;
    logic          out_last_next;

    stub_t         stub_mem [STUB_DEPTH];
    stub_t         mem_q;
    logic          mem_we;
    logic [SW-1:0] mem_wa;
    stub_t         mem_wd;
    logic [SW-1:0] mem_ra;

    logic [CW-1:0] lim;
    logic [CW-1:0] srch_inc;
    logic [31:0]   le32_at1;
    logic [31:0]   le32_at2;
    logic [31:0]   cmp_val;
    logic [31:0]   rel;
    logic [32:0]   range_top;
    logic          in_range;
    logic          out_free;
    logic          more;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_address = out_addr_reg;
    assign patch_kind  = out_kind_reg;
    assign run_last    = out_last_reg;

    assign le32_at1  = {win_reg[4], win_reg[3], win_reg[2], win_reg[1]};
    assign le32_at2  = {win_reg[5], win_reg[4], win_reg[3], win_reg[2]};
    assign range_top = {1'b0, cfg.import_dir_start} + {1'b0, cfg.import_dir_size};
    // The range is clipped at the top of the address space, never wrapped.
    assign in_range  = (key_reg >= cfg.import_dir_start) && ({1'b0, key_reg} < range_top);
    assign cmp_val   = (mode_reg == PATCH_INDIRECT) ? mem_q.slot_addr : mem_q.orig_target;
    assign rel       = mem_q.dest_addr - base5_reg;
    assign srch_inc  = srch_reg + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign more      = end_reg && (fill_reg != 3'd1);

    always_comb
    begin
        if (32'(cfg.active_stubs) > 32'(STUB_DEPTH))
        begin
            lim = CW'(STUB_DEPTH);
        end
        else
        begin
            lim = CW'(cfg.active_stubs);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        end_next       = end_reg;
        mode_next      = mode_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        base5_next     = base5_reg;
        srch_next      = srch_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        out_addr_next  = out_addr_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = SW'(q_head.slot_index);
        mem_wd         = '{q_head.slot_table_addr, q_head.slot_orig_target,
                           q_head.slot_stub_addr};
        mem_ra         = srch_inc[SW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_load)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        if (fill_reg == 3'd0)
                        begin
                            oldest_next = q_head.byte_address;
                        end
                        win_next[fill_reg] = q_head.code_byte;
                        fill_next          = fill_reg + 1'b1;
                        end_next           = q_head.section_end;
                        state_next         = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                kind_next = PATCH_NONE;
                if (fill_reg == WIN_FULL)
                begin
                    base5_next = oldest_reg + CALL_LEN;
                    if (win_reg[0] == BYTE_FF && win_reg[1] == BYTE_15)
                    begin
                        mode_next = PATCH_INDIRECT;
                        key_next  = le32_at2 - cfg.pref_base;
                    end
                    else if (win_reg[0] == BYTE_E8)
                    begin
                        mode_next = PATCH_DIRECT;
                        key_next  = oldest_reg + CALL_LEN + le32_at1;
                    end
                    else
                    begin
                        mode_next = PATCH_NONE;
                    end
                    state_next = S_CAND;
                end
                else if (end_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CAND:
            begin
                if ((mode_reg == PATCH_INDIRECT || (mode_reg == PATCH_DIRECT && in_range))
                    && lim != '0)
                begin
                    mem_ra     = '0;
                    srch_next  = '0;
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SEARCH:
            begin
                // One table entry per cycle; the first hit from slot zero up wins.
                if (cmp_val == key_reg)
                begin
                    if (mode_reg == PATCH_INDIRECT)
                    begin
                        win_next[0] = BYTE_E8;
                        win_next[5] = BYTE_90;
                    end
                    win_next[1] = rel[7:0];
                    win_next[2] = rel[15:8];
                    win_next[3] = rel[23:16];
                    win_next[4] = rel[31:24];
                    kind_next   = mode_reg;
                    state_next  = S_EMIT;
                end
                else if (srch_inc >= lim)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    srch_next = srch_inc;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = win_reg[0];
                    out_addr_next  = oldest_reg;
                    out_kind_next  = kind_reg;
                    out_last_next  = !more;
                    for (int i = 0; i < WIN_LEN - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    fill_next   = fill_reg - 1'b1;
                    oldest_next = oldest_reg + 32'd1;
                    kind_next   = PATCH_NONE;
                    state_next  = more ? S_EMIT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            end_reg       <= 1'b0;
            mode_reg      <= PATCH_NONE;
            kind_reg      <= PATCH_NONE;
            srch_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            end_reg       <= end_next;
            mode_reg      <= mode_next;
            kind_reg      <= kind_next;
            srch_reg      <= srch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        base5_reg    <= base5_next;
        win_reg      <= win_next;
        out_byte_reg <= out_byte_next;
        out_addr_reg <= out_addr_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stub_mem[mem_wa] <= mem_wd;
        end
        mem_q <= stub_mem[mem_ra];
    end

endmodule

@@ rtl/csrd_checker.sv @@
// Port-level checks for the call site redirector, bound to the top level.
`timescale 1ns / 1ps

module csrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic [31:0] out_address,
    input logic [1:0]  patch_kind,
    input logic        run_last
);
    import csrd_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(out_address)
            && $stable(patch_kind) && $stable(run_last))
        else $error("stalled result changed");

    // Every rewritten call, indirect or direct, starts with the E8 opcode.
    a_patch_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (patch_kind == PATCH_INDIRECT || patch_kind == PATCH_DIRECT)
            |-> out_byte == BYTE_E8)
        else $error("patched call does not start with E8");

    // No result can appear in the cycle right after reset is seen.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

endmodule

bind call_site_redirector_unit csrd_checker u_csrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_address (out_address),
    .patch_kind  (patch_kind),
    .run_last    (run_last)
);
